// ===== rtl/gcd_pkg.sv =====
// Package: shared types, constants and CORDIC angle table for the great-circle distance core
package gcd_pkg;

   localparam int CORDIC_STAGES = 32;
   localparam int SQRT_STEPS = 32;

   // Channel word widths
   localparam int REQ_W = 126;
   localparam int RSP_W = 35;

   // Angle and coordinate constants (radians in Q2.30)
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] DEG_K = (PI_Q60 + 64'd900000000) / 64'd1800000000;
   localparam logic signed [39:0] PI_Q30 = 40'((PI_Q60 + (64'd1 << 29)) >> 30);
   localparam logic signed [39:0] HALF_PI_Q30 = 40'((PI_Q60 + (64'd1 << 30)) >> 31);
   localparam logic signed [39:0] ONE_Q30 = 40'sd1073741824;
   localparam logic [33:0] ONE_Q32 = 34'h100000000;
   localparam logic signed [39:0] GAIN_INV_Q30 = 40'sd652032874;
   localparam logic [32:0] EARTH_RADIUS_MM = 33'd6371000000;
   localparam logic signed [31:0] LAT_LIMIT = 32'sd900000000;

   // Datapath width for CORDIC x/y/z
   localparam int CW = 40;
   typedef logic signed [CW-1:0] cw_type;

   // Angle step table depth, covers every supported stage count
   localparam int ANGLE_DEPTH = 64;
   typedef cw_type [ANGLE_DEPTH-1:0] angle_table_type;

   // Rotation cell word: four independent rotations travel together
   typedef struct packed {
      cw_type [3:0] x;
      cw_type [3:0] y;
      cw_type [3:0] z;
   } rot_type;

   // Vectoring cell word
   typedef struct packed {
      cw_type x;
      cw_type y;
      cw_type z;
   } vec_type;

   // Square-root cell word: two roots in parallel
   typedef struct packed {
      logic [1:0][63:0] v;
      logic [1:0][63:0] r;
   } sqr_type;

   // atan(2^-i) in Q2.30 from the power series in Q62
   function automatic cw_type step_angle(input int i);
      logic [63:0] sum;
      logic [63:0] term;
      int sh;
      sum = 64'd0;
      if (i == 0) begin
         return cw_type'((PI_Q60 + (64'd1 << 31)) >> 32);
      end
      for (int k = 0; k < 64; k++) begin
         sh = i * (2 * k + 1);
         if (sh <= 62) begin
            term = (64'd1 << (62 - sh)) / 64'(2 * k + 1);
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
      end
      return cw_type'((sum + (64'd1 << 31)) >> 32);
   endfunction

   // Constant table of angle steps, indexed by stage
   function automatic angle_table_type build_angle_table();
      angle_table_type tbl;
      for (int i = 0; i < ANGLE_DEPTH; i++) tbl[i] = step_angle(i);
      return tbl;
   endfunction

   localparam angle_table_type ANGLE_TABLE = build_angle_table();

   // Degrees*1e7 difference to radians, right shift sh, sign applied after rounding
   function automatic cw_type to_radians(input logic signed [32:0] d, input int sh);
      logic [32:0] m;
      logic [95:0] p;
      m = d[32] ? 33'(-d) : 33'(d);
      p = (96'(m) * 96'(DEG_K) + (96'd1 << (sh - 1))) >> sh;
      return d[32] ? -cw_type'(p[CW-1:0]) : cw_type'(p[CW-1:0]);
   endfunction

endpackage

// ===== rtl/gcd_if.sv =====
// Interfaces: valid/ready channels for the point-pair request and distance result words
interface gcd_req_if;
   logic valid;
   logic ready;
   logic [gcd_pkg::REQ_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface gcd_rsp_if;
   logic valid;
   logic ready;
   logic [gcd_pkg::RSP_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/great_circle_distance_core.sv =====
// Top level: pipelined haversine distance, rotation/sqrt/vectoring cell chains
// Register order: pre stages, rotation cells, mid stages, square-root cells, vectoring cells, post stages.
// Throughput: one word per cycle; the whole pipeline advances when the output
// register is empty or being taken, so a stall holds every stage.
// Reset: synchronous, clears only the stage valid bits; the block keeps no state.
module great_circle_distance_core (
   input  logic clock,
   input  logic reset,
   gcd_req_if.sink   req,
   gcd_rsp_if.source rsp
);
   localparam int NR = gcd_pkg::CORDIC_STAGES;
   localparam int NS = gcd_pkg::SQRT_STEPS;
   localparam int NV = gcd_pkg::CORDIC_STAGES;
   localparam int CW = gcd_pkg::CW;
   // total valid-bit stages
   localparam int PRE = 3;
   localparam int MID = 3;
   localparam int POST = 4;
   localparam int NTOT = PRE + NR + MID + NS + NV + POST;

   logic advance;
   logic [NTOT-1:0] vld_ff;
   logic [NTOT-1:0] vld_in;

   assign advance = !vld_ff[NTOT-1] || rsp.ready;
   assign req.ready = advance;

   // valid shift line
   assign vld_in = {vld_ff[NTOT-2:0], req.valid};
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= vld_in;
   end

   // ---- pre stage 0: unpack and clamp
   logic signed [31:0] lat1_ff, lat2_ff, lon1_ff, lon2_ff;
   logic signed [31:0] lat1_in, lat2_in;
   always_comb begin
      lat1_in = 32'(signed'(req.data[30:0]));
      lat2_in = 32'(signed'(req.data[93:63]));
      if (lat1_in > gcd_pkg::LAT_LIMIT) lat1_in = gcd_pkg::LAT_LIMIT;
      if (lat1_in < -gcd_pkg::LAT_LIMIT) lat1_in = -gcd_pkg::LAT_LIMIT;
      if (lat2_in > gcd_pkg::LAT_LIMIT) lat2_in = gcd_pkg::LAT_LIMIT;
      if (lat2_in < -gcd_pkg::LAT_LIMIT) lat2_in = -gcd_pkg::LAT_LIMIT;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         lat1_ff <= lat1_in;
         lat2_ff <= lat2_in;
         lon1_ff <= signed'(req.data[62:31]);
         lon2_ff <= signed'(req.data[125:94]);
      end
   end

   // ---- pre stage 1: to radians
   gcd_pkg::cw_type a1_ff, a2_ff, hl_ff, hn_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         a1_ff <= gcd_pkg::to_radians(33'(lat1_ff), 30);
         a2_ff <= gcd_pkg::to_radians(33'(lat2_ff), 30);
         hl_ff <= gcd_pkg::to_radians(33'(lat2_ff) - 33'(lat1_ff), 31);
         hn_ff <= gcd_pkg::to_radians(33'(lon2_ff) - 33'(lon1_ff), 31);
      end
   end

   // ---- pre stage 2: longitude wrap (|hn| < 3*pi/2, one correction suffices)
   gcd_pkg::rot_type rot [NR+1];
   gcd_pkg::rot_type rot0_ff;
   gcd_pkg::cw_type hn_w;
   always_comb begin
      hn_w = hn_ff;
      if (hn_w > gcd_pkg::HALF_PI_Q30) hn_w = hn_w - gcd_pkg::PI_Q30;
      else if (hn_w < -gcd_pkg::HALF_PI_Q30) hn_w = hn_w + gcd_pkg::PI_Q30;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < 4; l++) begin
            rot0_ff.x[l] <= gcd_pkg::GAIN_INV_Q30;
            rot0_ff.y[l] <= '0;
         end
         rot0_ff.z[0] <= a1_ff;
         rot0_ff.z[1] <= a2_ff;
         rot0_ff.z[2] <= hl_ff;
         rot0_ff.z[3] <= hn_w;
      end
   end
   assign rot[0] = rot0_ff;

   // ---- rotation cell chain
   for (genvar i = 0; i < NR; i++) begin : g_rot
      gcd_rot_cell u_cell (
         .clock(clock), .enable(advance), .stage(6'(i)),
         .d_in(rot[i]), .d_out(rot[i+1])
      );
   end

   // ---- mid stage 0: clamp cos/sin, square sines, cos product
   function automatic gcd_pkg::cw_type clamp_s(input gcd_pkg::cw_type v);
      if (v > gcd_pkg::ONE_Q30) return gcd_pkg::ONE_Q30;
      if (v < -gcd_pkg::ONE_Q30) return -gcd_pkg::ONE_Q30;
      return v;
   endfunction
   function automatic logic [33:0] square_q32(input gcd_pkg::cw_type s);
      gcd_pkg::cw_type c;
      logic [30:0] m;
      logic [61:0] p;
      c = clamp_s(s);
      m = c[CW-1] ? 31'(-c) : 31'(c);
      p = 62'(m) * 62'(m);
      return 34'((p + 62'd134217728) >> 28);
   endfunction
   function automatic logic [30:0] clamp_c(input gcd_pkg::cw_type v);
      if (v[CW-1]) return '0;
      if (v > gcd_pkg::ONE_Q30) return 31'(gcd_pkg::ONE_Q30);
      return 31'(v);
   endfunction
   logic [33:0] sql_ff, sqn_ff;
   logic [30:0] cp_ff;
   logic [61:0] cpp;
   assign cpp = 62'(clamp_c(rot[NR].x[0])) * 62'(clamp_c(rot[NR].x[1]));
   always_ff @(posedge clock) begin
      if (advance) begin
         sql_ff <= square_q32(rot[NR].y[2]);
         sqn_ff <= square_q32(rot[NR].y[3]);
         cp_ff <= 31'((cpp + 62'd536870912) >> 30);
      end
   end

   // ---- mid stage 1: product term
   logic [33:0] sql2_ff, pt_ff;
   logic [64:0] ptp;
   assign ptp = 65'(cp_ff) * 65'(sqn_ff);
   always_ff @(posedge clock) begin
      if (advance) begin
         sql2_ff <= sql_ff;
         pt_ff <= 34'((ptp + 65'd536870912) >> 30);
      end
   end

   // ---- mid stage 2: sum, clamp, set up roots
   gcd_pkg::sqr_type sq [NS+1];
   gcd_pkg::sqr_type sq0_ff;
   logic [34:0] asum;
   logic [33:0] aq;
   assign asum = 35'(sql2_ff) + 35'(pt_ff);
   assign aq = (asum > 35'(gcd_pkg::ONE_Q32)) ? gcd_pkg::ONE_Q32 : asum[33:0];
   always_ff @(posedge clock) begin
      if (advance) begin
         sq0_ff.v[0] <= 64'(aq) << 28;
         sq0_ff.v[1] <= 64'(gcd_pkg::ONE_Q32 - aq) << 28;
         sq0_ff.r[0] <= '0;
         sq0_ff.r[1] <= '0;
      end
   end
   assign sq[0] = sq0_ff;

   // ---- square-root cell chain
   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      gcd_sqrt_cell u_cell (
         .clock(clock), .enable(advance), .stage(6'(i)),
         .d_in(sq[i]), .d_out(sq[i+1])
      );
   end

   // ---- vectoring cell chain (x = sqrt(1-a), y = sqrt(a))
   gcd_pkg::vec_type vc [NV+1];
   assign vc[0].x = CW'(sq[NS].r[1]);
   assign vc[0].y = CW'(sq[NS].r[0]);
   assign vc[0].z = '0;
   for (genvar i = 0; i < NV; i++) begin : g_vec
      gcd_vec_cell u_cell (
         .clock(clock), .enable(advance), .stage(6'(i)),
         .d_in(vc[i]), .d_out(vc[i+1])
      );
   end

   // ---- post stage 0: c = 2*max(z,0)
   logic [31:0] c_ff;
   always_ff @(posedge clock) begin
      if (advance) c_ff <= vc[NV].z[CW-1] ? '0 : 32'(vc[NV].z <<< 1);
   end

   // ---- post stage 1: two partial products
   logic [63:0] q_ff, t_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff <= 64'(gcd_pkg::EARTH_RADIUS_MM) * 64'(c_ff[31:15]);
         t_ff <= 64'(gcd_pkg::EARTH_RADIUS_MM) * 64'(c_ff[14:0]);
      end
   end

   // ---- post stage 2: combine
   logic [34:0] dist_ff;
   always_ff @(posedge clock) begin
      if (advance) dist_ff <= 35'((q_ff >> 15) + ((((q_ff & 64'h7FFF) << 15) + t_ff) >> 30));
   end

   // ---- post stage 3: output register
   logic [34:0] out_ff;
   always_ff @(posedge clock) begin
      if (advance) out_ff <= dist_ff;
   end
   assign rsp.valid = vld_ff[NTOT-1];
   assign rsp.data = out_ff;

`ifndef NO_ASSERTIONS
   // a stalled result holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");
   // pipeline accepts whenever output is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input stalled with empty output");
   // distance never exceeds half circumference
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.data <= 35'd20015100000)
      else $error("distance out of range");
`endif
endmodule

// ===== rtl/gcd_rot_cell.sv =====
// Rotation-mode CORDIC cell: one micro-rotation stage for four angles
module gcd_rot_cell (
   input  logic clock,
   input  logic enable,
   input  logic [5:0] stage,
   input  gcd_pkg::rot_type d_in,
   output gcd_pkg::rot_type d_out
);
   gcd_pkg::rot_type q_ff;
   gcd_pkg::rot_type q_in;
   gcd_pkg::cw_type t;

   // shift-add update of each lane
   always_comb begin
      t = gcd_pkg::ANGLE_TABLE[stage];
      q_in = d_in;
      for (int l = 0; l < 4; l++) begin
         if (!d_in.z[l][gcd_pkg::CW-1]) begin
            q_in.x[l] = d_in.x[l] - (d_in.y[l] >>> stage);
            q_in.y[l] = d_in.y[l] + (d_in.x[l] >>> stage);
            q_in.z[l] = d_in.z[l] - t;
         end else begin
            q_in.x[l] = d_in.x[l] + (d_in.y[l] >>> stage);
            q_in.y[l] = d_in.y[l] - (d_in.x[l] >>> stage);
            q_in.z[l] = d_in.z[l] + t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) q_ff <= q_in;
   end
   assign d_out = q_ff;
endmodule

// ===== rtl/gcd_vec_cell.sv =====
// Vectoring-mode CORDIC cell: one micro-rotation stage toward the x axis
module gcd_vec_cell (
   input  logic clock,
   input  logic enable,
   input  logic [5:0] stage,
   input  gcd_pkg::vec_type d_in,
   output gcd_pkg::vec_type d_out
);
   gcd_pkg::vec_type q_ff;
   gcd_pkg::vec_type q_in;
   gcd_pkg::cw_type t;

   always_comb begin
      t = gcd_pkg::ANGLE_TABLE[stage];
      if (!d_in.y[gcd_pkg::CW-1]) begin
         q_in.x = d_in.x + (d_in.y >>> stage);
         q_in.y = d_in.y - (d_in.x >>> stage);
         q_in.z = d_in.z + t;
      end else begin
         q_in.x = d_in.x - (d_in.y >>> stage);
         q_in.y = d_in.y + (d_in.x >>> stage);
         q_in.z = d_in.z - t;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) q_ff <= q_in;
   end
   assign d_out = q_ff;
endmodule

// ===== rtl/gcd_sqrt_cell.sv =====
// Square-root cell: one restoring bit step for two floor roots
module gcd_sqrt_cell (
   input  logic clock,
   input  logic enable,
   input  logic [5:0] stage,
   input  gcd_pkg::sqr_type d_in,
   output gcd_pkg::sqr_type d_out
);
   gcd_pkg::sqr_type q_ff;
   gcd_pkg::sqr_type q_in;
   logic [63:0] bitv;
   logic [63:0] trial;

   always_comb begin
      bitv = 64'd1 << (7'd62 - {stage, 1'b0});
      q_in = d_in;
      trial = '0;
      for (int l = 0; l < 2; l++) begin
         trial = d_in.r[l] + bitv;
         if (d_in.v[l] >= trial) begin
            q_in.v[l] = d_in.v[l] - trial;
            q_in.r[l] = (d_in.r[l] >> 1) + bitv;
         end else begin
            q_in.r[l] = d_in.r[l] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) q_ff <= q_in;
   end
   assign d_out = q_ff;
endmodule

// ===== sim/gcd_tb_if.sv =====
// Bench package: request word layout for the point-pair channel
`timescale 1ns / 100ps
package gcd_tb_pkg;

   // Request word layout, first latitude in the lowest bits
   typedef struct packed {
      logic signed [31:0] second_longitude;
      logic signed [30:0] second_latitude;
      logic signed [31:0] first_longitude;
      logic signed [30:0] first_latitude;
   } point_pair_type;

endpackage

// ===== sim/tb_great_circle_distance_core.sv =====
// Testbench: haversine distance core checked against a bit-exact fixed-point predictor
`timescale 1ns / 100ps
module tb_great_circle_distance_core;

   localparam int LATENCY = 106;
   localparam longint CYCLE_LIMIT = 600000;
   localparam longint LAT_MAX = 900000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gcd_req_if req_if ();
   gcd_rsp_if rsp_if ();

   great_circle_distance_core dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   always #10 clock = ~clock;

   logic [34:0] distance_queue[$];
   longint atan_step[64];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   longint cycles = 0;
   bit no_idle = 1'b0;

   // ---------------- predictor ----------------
   function automatic longint atan_of_pow2(int i);
      longint unsigned sum, term;
      int sh;
      sum = 0;
      if (i == 0) return longint'((gcd_pkg::PI_Q60 + (64'd1 << 31)) >> 32);
      for (int k = 0; k < 64; k++) begin
         sh = i * (2 * k + 1);
         if (sh <= 62) begin
            term = (64'd1 << (62 - sh)) / longint'(2 * k + 1);
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
      end
      return longint'((sum + (64'd1 << 31)) >> 32);
   endfunction

   function automatic longint deg_to_rad(longint d, int sh);
      longint unsigned m, r;
      m = (d < 0) ? longint'(-d) : d;
      r = (m * gcd_pkg::DEG_K + (64'd1 << (sh - 1))) >> sh;
      return (d < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint limit(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic void sin_cos(longint angle, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = gcd_pkg::GAIN_INV_Q30; y = 0; z = angle;
      for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step[i];
         end else begin
            x += dx; y -= dy; z += atan_step[i];
         end
      end
      c = x; s = y;
   endfunction

   function automatic longint arctan(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_step[i];
         end else begin
            x -= dx; y += dy; z -= atan_step[i];
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0; bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bitv) begin
            v -= res + bitv; res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint sine_square(longint s);
      longint unsigned m;
      s = limit(s, -gcd_pkg::ONE_Q30, gcd_pkg::ONE_Q30);
      m = (s < 0) ? longint'(-s) : s;
      return longint'((m * m + (64'd1 << 27)) >> 28);
   endfunction

   function automatic logic [34:0] predict_distance(gcd_tb_pkg::point_pair_type p);
      longint lat1, lon1, lat2, lon2, hl, hn, pi30, hpi30;
      longint c1, s1, c2, s2, cl, sl, cn, sn, cp, a, c;
      longint unsigned ya, xa, q, t, span, r;
      pi30 = gcd_pkg::PI_Q30; hpi30 = gcd_pkg::HALF_PI_Q30; r = gcd_pkg::EARTH_RADIUS_MM;
      lat1 = limit(longint'(p.first_latitude), -LAT_MAX, LAT_MAX);
      lon1 = longint'(p.first_longitude);
      lat2 = limit(longint'(p.second_latitude), -LAT_MAX, LAT_MAX);
      lon2 = longint'(p.second_longitude);
      hl = deg_to_rad(lat2 - lat1, 31);
      hn = deg_to_rad(lon2 - lon1, 31);
      // longitude wrap onto [-pi/2, pi/2]
      while (hn > hpi30) hn -= pi30;
      while (hn < -hpi30) hn += pi30;
      sin_cos(deg_to_rad(lat1, 30), c1, s1);
      sin_cos(deg_to_rad(lat2, 30), c2, s2);
      sin_cos(hl, cl, sl);
      sin_cos(hn, cn, sn);
      c1 = limit(c1, 0, gcd_pkg::ONE_Q30);
      c2 = limit(c2, 0, gcd_pkg::ONE_Q30);
      cp = longint'((longint'(c1) * c2 + (64'd1 << 29)) >> 30);
      a = sine_square(sl)
          + longint'((longint'(cp) * sine_square(sn) + (64'd1 << 29)) >> 30);
      a = limit(a, 0, longint'(gcd_pkg::ONE_Q32));
      ya = isqrt(longint'(a) << 28);
      xa = isqrt((longint'(gcd_pkg::ONE_Q32) - a) << 28);
      c = 2 * arctan(longint'(xa), longint'(ya));
      q = r * (longint'(c) >> 15);
      t = r * (longint'(c) & 64'h7FFF);
      span = (q >> 15) + ((((q & 64'h7FFF) << 15) + t) >> 30);
      return span[34:0];
   endfunction

   // ---------------- stimulus ----------------
   task automatic send_pair(longint lat1, longint lon1, longint lat2, longint lon2);
      gcd_tb_pkg::point_pair_type p;
      int gap;
      p.first_latitude = lat1[30:0];
      p.first_longitude = lon1[31:0];
      p.second_latitude = lat2[30:0];
      p.second_longitude = lon2[31:0];
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= p;
      do @(posedge clock); while (!req_if.ready);
      distance_queue.insert(distance_queue.size(), predict_distance(p));
      words_sent++;
   endtask

   function automatic longint rand_lat();
      return longint'($urandom_range(0, 1800000000)) - LAT_MAX;
   endfunction

   function automatic longint rand_lon();
      return longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
   endfunction

   task automatic test_directed();
      send_pair(0, 0, 0, 0);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0);
      send_pair(0, 0, 0, 1800000000);
      send_pair(0, -1800000000, 0, 1800000000);
      send_pair(0, 0, 1, 1);
      send_pair(-LAT_MAX, 1800000000, LAT_MAX, -1800000000);
      // raw latitudes beyond the pole are clamped
      send_pair(-(64'sd1 << 30), 0, (64'sd1 << 30) - 1, 0);
      send_pair((64'sd1 << 30) - 1, 123, 900000001, -456);
      // full-width longitudes exercise the longitude wrap
      send_pair(0, -(64'sd1 << 31), 0, (64'sd1 << 31) - 1);
      send_pair(450000000, (64'sd1 << 31) - 1, -450000000, -(64'sd1 << 31));
      send_pair(0, 900000000, 0, -900000000);
      send_pair(0, 0, 0, 900000001);
      send_pair(0, 0, 0, 899999999);
      send_pair(LAT_MAX, 0, LAT_MAX, 1800000000);
      send_pair(-1, -1, 1, 1);
      send_pair(523000000, 134000000, 523000001, 134000000);
      send_pair(0, 0, 0, 1799999999);
      send_pair(-LAT_MAX, -1, -LAT_MAX, 0);
   endtask

   task automatic test_random(int count);
      longint lat1, lon1, lat2, lon2;
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) no_idle = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0: begin
               // full field range including out-of-range latitudes
               lat1 = $signed(31'($urandom)); lon1 = $signed(32'($urandom));
               lat2 = $signed(31'($urandom)); lon2 = $signed(32'($urandom));
            end
            1: begin
               // nearby points
               lat1 = rand_lat(); lon1 = rand_lon();
               lat2 = limit(lat1 + $signed(32'($urandom_range(0, 2000))) - 1000,
                            -LAT_MAX, LAT_MAX);
               lon2 = lon1 + $signed(32'($urandom_range(0, 2000))) - 1000;
            end
            2: begin
               // near-antipodal points
               lat1 = rand_lat(); lon1 = rand_lon();
               lat2 = -lat1 + $urandom_range(0, 100) - 50;
               lon2 = (lon1 >= 0) ? lon1 - 1800000000 : lon1 + 1800000000;
               lon2 = lon2 + $urandom_range(0, 100) - 50;
            end
            default: begin
               lat1 = rand_lat(); lon1 = rand_lon();
               lat2 = rand_lat(); lon2 = rand_lon();
            end
         endcase
         send_pair(lat1, lon1, lat2, lon2);
      end
      no_idle = 1'b0;
   endtask

   // ---------------- result side ----------------
   initial begin
      int hold;
      rsp_if.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 12);
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // Compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      logic [34:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (distance_queue.size() == 0) begin
            $error("unexpected result word distance_mm=%0d", rsp_if.data);
            errors++;
         end else begin
            want = distance_queue.pop_front();
            words_checked++;
            if (rsp_if.data !== want) begin
               $error("distance_mm mismatch: expected %0d actual %0d", want, rsp_if.data);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------- main sequence ----------------
   initial begin
      for (int i = 0; i < 64; i++) atan_step[i] = atan_of_pow2(i);
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1800);
      req_if.valid <= 1'b0;
      while (distance_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("Sent %0d point pairs (directed poles, wraps, clamps; random near/antipodal/full-range),",
               words_sent);
      $display("checked %0d distance words with random gaps and stalls on both sides.",
               words_checked);
      if (errors == 0 && distance_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== great_circle_distance_core.f =====
rtl/gcd_pkg.sv
rtl/gcd_if.sv
rtl/gcd_rot_cell.sv
rtl/gcd_vec_cell.sv
rtl/gcd_sqrt_cell.sv
rtl/great_circle_distance_core.sv
sim/gcd_tb_if.sv
sim/tb_great_circle_distance_core.sv
